// ===== hdl/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Command and status codes, the queue entry passed from front to back end,
// the back-end state type and the find-first-set helper.
// ----------------------------------------------------------------------------
package bba_pkg;

  // default geometry
  localparam int BITMAP_BYTES_DEF  = 4096;
  localparam int HEADER_BLOCKS_DEF = 2;

  // fixed field widths
  localparam int BLK_W   = 15;
  localparam int LIMIT_W = 16;

  // one memory word holds the bits of eight bitmap bytes
  localparam int WORD_LOG   = 6;
  localparam int WORD_BITS  = 1 << WORD_LOG;
  localparam int WORD_BYTES = WORD_BITS / 8;

  // depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTALLOC = 2'd2,
    ST_NULL     = 2'd3
  } status_t;

  // work classes decided by the front end
  typedef enum logic [2:0] {
    OP_NULL     = 3'd0,
    OP_ALLOC    = 3'd1,
    OP_FREE     = 3'd2,
    OP_RESERVE  = 3'd3,
    OP_QUERY    = 3'd4,
    OP_NOP      = 3'd5,
    OP_NOTALLOC = 3'd6
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BLK_W-1:0] blk;
  } entry_t;

  typedef enum logic [2:0] {
    BK_CLEAR     = 3'd0,
    BK_IDLE      = 3'd1,
    BK_ALLOC_SUM = 3'd2,
    BK_ALLOC_DAT = 3'd3,
    BK_UPDATE    = 3'd4
  } bk_state_t;

  // index of the lowest set bit of a word, zero when none is set
  function automatic logic [WORD_LOG-1:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [WORD_LOG-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WORD_LOG'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bba_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_front: command intake and classification
// Takes input transfers, checks the null pointer and the block range, and
// pushes one classified entry per transfer into the work queue.
// ----------------------------------------------------------------------------
module bba_front #(
  parameter int BITMAP_BYTES = bba_pkg::BITMAP_BYTES_DEF
) (
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_command,
  input  wire logic [bba_pkg::BLK_W-1:0] in_block_number,
  input  wire logic                      in_null_pointer,
  input  wire logic                      q_full,
  input  wire logic                      clearing,
  output logic                           push,
  output bba_pkg::entry_t                entry
);
  import bba_pkg::*;

  logic in_map;
  logic nonzero;

  // hold off intake while the queue is full or the bitmap is being cleared
  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  // range checks on the block number
  assign in_map  = (32'(in_block_number) >> 3) < 32'(BITMAP_BYTES);
  assign nonzero = |in_block_number;

  // classify the command
  always_comb begin
    entry.blk = in_block_number;
    entry.op  = OP_NOP;
    if (in_null_pointer) begin
      entry.op = OP_NULL;
    end else begin
      unique case (cmd_t'(in_command))
        CMD_ALLOC:   entry.op = OP_ALLOC;
        CMD_FREE:    entry.op = (in_map && nonzero) ? OP_FREE : OP_NOTALLOC;
        CMD_RESERVE: entry.op = in_map ? OP_RESERVE : OP_NOP;
        CMD_QUERY:   entry.op = (in_map && nonzero) ? OP_QUERY : OP_NOP;
        default:     entry.op = OP_NOP;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bba_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_queue: work queue between front and back end
// A short first-in first-out buffer of classified entries.
// ----------------------------------------------------------------------------
module bba_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bba_pkg::entry_t push_entry,
  input  wire logic            pop,
  output bba_pkg::entry_t      pop_entry,
  output logic                 empty,
  output logic                 full
);
  import bba_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_nxt;

  assign empty     = (count_r == '0);
  assign full      = (32'(count_r) == QUEUE_DEPTH);
  assign pop_entry = slot_r[rd_ptr_r];

  // pointer wrap
  assign wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bba_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_back: bitmap execution engine
// Holds the free bitmap in a word memory with a summary memory (one bit per
// nonempty word) and a top vector (one bit per nonempty summary word), runs
// allocate, free, reserve and query on them and registers the result.
// ----------------------------------------------------------------------------
module bba_back #(
  parameter int BITMAP_BYTES  = bba_pkg::BITMAP_BYTES_DEF,
  parameter int HEADER_BLOCKS = bba_pkg::HEADER_BLOCKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bba_pkg::entry_t             q_entry,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  input  wire logic [bba_pkg::LIMIT_W-1:0] setup_limit,
  output logic                             clearing,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bba_pkg::BLK_W-1:0]        out_allocated_block,
  output logic [1:0]                       out_status,
  output logic                             out_is_allocated,
  output logic                             out_limit_hit
);
  import bba_pkg::*;

  localparam int NW      = (BITMAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int NS      = (NW + WORD_BITS - 1) / WORD_BITS;
  localparam int WW      = (NW > 1) ? $clog2(NW) : 1;
  localparam int SW      = (NS > 1) ? $clog2(NS) : 1;
  localparam int GW      = WW + WORD_LOG;
  localparam int HDR_RAW = (HEADER_BLOCKS + 3) / 8 + 1;
  localparam int HDR     = (HDR_RAW > BITMAP_BYTES) ? BITMAP_BYTES : HDR_RAW;

  typedef logic [WORD_BITS-1:0] word_t;

  // reset contents of one bitmap word
  function automatic word_t init_word(input logic [WW-1:0] w);
    word_t v;
    int    b;
    v = '0;
    for (int k = 0; k < WORD_BYTES; k++) begin
      b = int'(w) * WORD_BYTES + k;
      if (b >= HDR && b < BITMAP_BYTES) begin
        v[k*8 +: 8] = 8'hff;
      end
    end
    return v;
  endfunction

  // reset contents of one summary word
  function automatic word_t init_sum(input logic [SW-1:0] s);
    word_t v;
    int    wd;
    v = '0;
    for (int t = 0; t < WORD_BITS; t++) begin
      wd   = int'(s) * WORD_BITS + t;
      v[t] = (wd < NW) && (wd * WORD_BYTES + WORD_BYTES - 1 >= HDR) &&
             (BITMAP_BYTES > HDR);
    end
    return v;
  endfunction

  // state and context
  bk_state_t          state_r, state_nxt;
  logic [WW-1:0]      clr_cnt_r;
  logic [NS-1:0]      top_r;
  logic [WW-1:0]      w_r, w_in;
  logic               w_load;
  logic [SW-1:0]      s_r, s_in;
  logic               s_load;
  logic [WORD_LOG-1:0] bit_r;
  op_t                op_r;
  logic               ctx_load;
  word_t              sum_word_r;
  logic               sum_word_load;
  logic               limit_flag_r;
  logic               set_limit;

  // memories
  word_t              data_mem [NW];
  word_t              sum_mem  [NS];
  word_t              data_q, sum_q;
  logic [WW-1:0]      data_raddr, data_waddr;
  logic [SW-1:0]      sum_raddr, sum_waddr;
  logic               data_we, sum_we;
  word_t              data_wdata, sum_wdata;
  logic               top_we, top_wval;
  logic [SW-1:0]      top_widx;

  // result register
  logic               out_valid_r;
  logic [BLK_W-1:0]   out_block_r;
  status_t            out_status_r;
  logic               out_answer_r;
  logic               out_limit_r;
  logic               res_we;
  logic [BLK_W-1:0]   res_block;
  status_t            res_status;
  logic               res_answer;

  // helpers
  logic               slot_free;
  logic [SW-1:0]      top_first;
  logic [WW-1:0]      ent_w;
  logic [SW-1:0]      ent_s;
  logic [WW-1:0]      alloc_w;
  logic [WORD_LOG-1:0] dbit;
  word_t              dmask, wmask;
  word_t              new_d, new_s;
  logic [GW-1:0]      granted;
  logic               hit;

  assign clearing  = (state_r == BK_CLEAR);
  assign slot_free = !out_valid_r || !out_stall;

  // lowest nonempty summary word
  always_comb begin
    top_first = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (top_r[i]) begin
        top_first = SW'(i);
      end
    end
  end

  // address split of the queued block number
  assign ent_w   = WW'(32'(q_entry.blk) >> WORD_LOG);
  assign ent_s   = SW'(32'(ent_w) >> WORD_LOG);
  assign alloc_w = WW'({s_r, first_set(sum_q)});
  assign dbit    = first_set(data_q);
  assign granted = GW'({w_r, dbit});
  assign hit     = (setup_limit != '0) && (32'(granted) >= 32'(setup_limit));
  assign wmask   = word_t'(1) << WORD_LOG'(32'(w_r));

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    ctx_load      = 1'b0;
    w_load        = 1'b0;
    w_in          = ent_w;
    s_load        = 1'b0;
    s_in          = ent_s;
    sum_word_load = 1'b0;
    data_raddr    = w_r;
    sum_raddr     = s_r;
    data_we       = 1'b0;
    data_waddr    = w_r;
    data_wdata    = data_q;
    sum_we        = 1'b0;
    sum_waddr     = s_r;
    sum_wdata     = sum_q;
    top_we        = 1'b0;
    top_widx      = s_r;
    top_wval      = 1'b0;
    res_we        = 1'b0;
    res_block     = '0;
    res_status    = ST_OK;
    res_answer    = 1'b0;
    set_limit     = 1'b0;
    dmask         = word_t'(1) << bit_r;
    new_d         = data_q;
    new_s         = sum_q;

    unique case (state_r)
      // sweep reset contents into the memories
      BK_CLEAR: begin
        data_we    = 1'b1;
        data_waddr = clr_cnt_r;
        data_wdata = init_word(clr_cnt_r);
        if (32'(clr_cnt_r) < NS) begin
          sum_we    = 1'b1;
          sum_waddr = SW'(clr_cnt_r);
          sum_wdata = init_sum(SW'(clr_cnt_r));
          top_we    = 1'b1;
          top_widx  = SW'(clr_cnt_r);
          top_wval  = |init_sum(SW'(clr_cnt_r));
        end
        if (32'(clr_cnt_r) == NW - 1) begin
          state_nxt = BK_IDLE;
        end
      end

      // dispatch the next queued entry
      BK_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop    = 1'b1;
          ctx_load = 1'b1;
          unique case (q_entry.op)
            OP_NULL: begin
              res_we     = 1'b1;
              res_status = ST_NULL;
            end
            OP_NOTALLOC: begin
              res_we     = 1'b1;
              res_status = ST_NOTALLOC;
            end
            OP_ALLOC: begin
              if (|top_r) begin
                s_load    = 1'b1;
                s_in      = top_first;
                sum_raddr = top_first;
                state_nxt = BK_ALLOC_SUM;
              end else begin
                res_we     = 1'b1;
                res_status = ST_FULL;
              end
            end
            OP_FREE, OP_RESERVE, OP_QUERY: begin
              w_load     = 1'b1;
              s_load     = 1'b1;
              data_raddr = ent_w;
              sum_raddr  = ent_s;
              state_nxt  = BK_UPDATE;
            end
            default: begin
              res_we = 1'b1;
            end
          endcase
        end
      end

      // summary word read: pick the lowest nonempty word
      BK_ALLOC_SUM: begin
        w_load        = 1'b1;
        w_in          = alloc_w;
        sum_word_load = 1'b1;
        data_raddr    = alloc_w;
        state_nxt     = BK_ALLOC_DAT;
      end

      // data word read: grant the lowest free bit
      BK_ALLOC_DAT: begin
        new_d      = data_q & ~(word_t'(1) << dbit);
        new_s      = sum_word_r & ~wmask;
        data_we    = 1'b1;
        data_wdata = new_d;
        if (new_d == '0) begin
          sum_we    = 1'b1;
          sum_wdata = new_s;
          if (new_s == '0) begin
            top_we   = 1'b1;
            top_wval = 1'b0;
          end
        end
        res_we    = 1'b1;
        res_block = BLK_W'(granted);
        set_limit = hit;
        state_nxt = BK_IDLE;
      end

      // free, reserve or query on one bit
      BK_UPDATE: begin
        state_nxt = BK_IDLE;
        res_we    = 1'b1;
        unique case (op_r)
          OP_FREE: begin
            if ((data_q & dmask) == '0) begin
              data_we    = 1'b1;
              data_wdata = data_q | dmask;
              sum_we     = 1'b1;
              sum_wdata  = sum_q | wmask;
              top_we     = 1'b1;
              top_wval   = 1'b1;
            end else begin
              res_status = ST_NOTALLOC;
            end
          end
          OP_RESERVE: begin
            new_d      = data_q & ~dmask;
            new_s      = sum_q & ~wmask;
            data_we    = 1'b1;
            data_wdata = new_d;
            if (new_d == '0) begin
              sum_we    = 1'b1;
              sum_wdata = new_s;
              if (new_s == '0) begin
                top_we   = 1'b1;
                top_wval = 1'b0;
              end
            end
          end
          OP_QUERY: begin
            res_answer = ((data_q & dmask) == '0);
          end
          default: begin
            res_answer = 1'b0;
          end
        endcase
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_CLEAR;
      clr_cnt_r    <= '0;
      top_r        <= '0;
      limit_flag_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (top_we) begin
        top_r[top_widx] <= top_wval;
      end
      if (set_limit) begin
        limit_flag_r <= 1'b1;
      end
    end
  end

  // per-item context
  always_ff @(posedge clk) begin
    if (ctx_load) begin
      op_r  <= q_entry.op;
      bit_r <= q_entry.blk[WORD_LOG-1:0];
    end
    if (w_load) begin
      w_r <= w_in;
    end
    if (s_load) begin
      s_r <= s_in;
    end
    if (sum_word_load) begin
      sum_word_r <= sum_q;
    end
  end

  // bitmap word memory
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    data_q <= data_mem[data_raddr];
  end

  // summary memory
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_q <= sum_mem[sum_raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_we) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      out_block_r  <= res_block;
      out_status_r <= res_status;
      out_answer_r <= res_answer;
      out_limit_r  <= limit_flag_r | set_limit;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_allocated_block = out_block_r;
  assign out_status          = out_status_r;
  assign out_is_allocated    = out_answer_r;
  assign out_limit_hit       = out_limit_r;

endmodule
`default_nettype wire

// ===== hdl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit block allocator over a free bitmap
// Front end classifies commands into a two-entry queue; back end executes
// them on a two-level summarized bitmap memory.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all ceil(BITMAP_BYTES/8)
// bitmap words (512 at the default size) that writes the initial bitmap;
// input stalls until it ends. The back end then answers straight from its
// dispatch state each item that needs no bitmap access (null pointer, block
// out of range, free or query of block 0, allocate with no free block). The
// other free, reserve and query commands read the 64-bit bitmap word and
// summary word, then write back where needed; allocate reads the summary
// word, then the bitmap word, then writes back. These steps come from the
// registered read ports of the bitmap and summary memories.
// A result is held in an output register, so new commands keep entering the
// queue, until it is full, while a result waits to be taken.
module bitmap_block_allocator #(
  parameter int BITMAP_BYTES  = bba_pkg::BITMAP_BYTES_DEF,
  parameter int HEADER_BLOCKS = bba_pkg::HEADER_BLOCKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_command,
  input  wire logic [bba_pkg::BLK_W-1:0]   in_block_number,
  input  wire logic                        in_null_pointer,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bba_pkg::BLK_W-1:0]        out_allocated_block,
  output logic [1:0]                       out_status,
  output logic                             out_is_allocated,
  output logic                             out_limit_hit,
  input  wire logic                        cfg_write_en,
  input  wire logic [bba_pkg::LIMIT_W-1:0] cfg_write_data
);
  import bba_pkg::*;

  logic [LIMIT_W-1:0] setup_limit_r;
  logic               q_full;
  logic               q_empty;
  logic               q_push;
  logic               q_pop;
  logic               clearing;
  entry_t             push_entry;
  entry_t             pop_entry;

  // setup limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_limit_r <= '0;
    end else if (cfg_write_en) begin
      setup_limit_r <= cfg_write_data;
    end
  end

  // command intake
  bba_front #(
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_block_number (in_block_number),
    .in_null_pointer (in_null_pointer),
    .q_full          (q_full),
    .clearing        (clearing),
    .push            (q_push),
    .entry           (push_entry)
  );

  // work queue
  bba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty),
    .full       (q_full)
  );

  // bitmap engine
  bba_back #(
    .BITMAP_BYTES  (BITMAP_BYTES),
    .HEADER_BLOCKS (HEADER_BLOCKS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_entry             (pop_entry),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .setup_limit         (setup_limit_r),
    .clearing            (clearing),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_allocated_block (out_allocated_block),
    .out_status          (out_status),
    .out_is_allocated    (out_is_allocated),
    .out_limit_hit       (out_limit_hit)
  );

endmodule
`default_nettype wire
